>>> hdl/cmaf_pkg.sv
// Shared constants, command and status types, and the reciprocal table of the box filter.
`default_nettype none
package cmaf_pkg;

    localparam int MAX_WINDOW   = 15;
    localparam int SAMPLE_BITS  = 16;
    localparam int WINDOW_BITS  = 4;
    localparam int WINDOW_RESET = 3;
    localparam int ADDR_BITS    = $clog2(MAX_WINDOW);
    localparam int SIDE_BITS    = 3;
    localparam int COUNT_BITS   = 5;
    localparam int COUNT_MAX    = 31;
    localparam int SUM_BITS     = SAMPLE_BITS + WINDOW_BITS;
    localparam int MAG_BITS     = SUM_BITS - 1;
    localparam int RECIP_BITS   = 24;
    localparam int PROD_BITS    = MAG_BITS + RECIP_BITS;

    // floor((2^24 - 1) / w); the quotient it gives is low by at most one.
    localparam logic [RECIP_BITS-1:0] RECIP_TABLE [16] = '{
        24'd0,       24'd16777215, 24'd8388607, 24'd5592405,
        24'd4194303, 24'd3355443,  24'd2796202, 24'd2396745,
        24'd2097151, 24'd1864135,  24'd1677721, 24'd1525201,
        24'd1398101, 24'd1290555,  24'd1198372, 24'd1118481
    };

    typedef struct packed {
        logic in_ready;
        logic rd_issue;
        logic abs_en;
        logic mul_en;
        logic fix_en;
        logic clr_avg;
        logic out_valid;
        logic flush_mode;
        logic flush_step;
    } cmaf_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic out_ready;
        logic full_sum;
        logic has_out;
        logic has_flush;
        logic last_issue;
        logic flush_one;
    } cmaf_status_t;

endpackage
`default_nettype wire

>>> hdl/cmaf_if.sv
// Handshake interfaces for the sample, result and window configuration channels.
`default_nettype none
interface cmaf_sample_if;
    import cmaf_pkg::*;
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          frame_end;
    modport source (output valid, output sample, output frame_end, input ready);
    modport sink (input valid, input sample, input frame_end, output ready);
endinterface

interface cmaf_result_if;
    import cmaf_pkg::*;
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] average;
    logic                          out_last;
    modport source (output valid, output average, output out_last, input ready);
    modport sink (input valid, input average, input out_last, output ready);
endinterface

interface cmaf_cfg_if;
    import cmaf_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [WINDOW_BITS-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hdl/cmaf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module cmaf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 15
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> hdl/cmaf_ctrl.sv
// Sequencing state machine of the box filter.
`default_nettype none
module cmaf_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cmaf_pkg::cmaf_status_t status,
    output cmaf_pkg::cmaf_cmd_t         cmd
);
    import cmaf_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_DECIDE = 9'b000000010,
        ST_READ   = 9'b000000100,
        ST_DRAIN  = 9'b000001000,
        ST_ABS    = 9'b000010000,
        ST_MUL    = 9'b000100000,
        ST_FIX    = 9'b001000000,
        ST_OUT    = 9'b010000000,
        ST_FLUSH  = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (status.in_valid)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (status.full_sum)
                begin
                    state_next = ST_READ;
                end
                else if (status.has_out)
                begin
                    cmd.clr_avg = 1'b1;
                    state_next  = ST_OUT;
                end
                else if (status.has_flush)
                begin
                    cmd.clr_avg = 1'b1;
                    state_next  = ST_FLUSH;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                cmd.rd_issue = 1'b1;
                if (status.last_issue)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_ABS;
            end
            ST_ABS:
            begin
                cmd.abs_en = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = ST_FIX;
            end
            ST_FIX:
            begin
                cmd.fix_en = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                cmd.out_valid = 1'b1;
                if (status.out_ready)
                begin
                    if (status.has_flush)
                    begin
                        cmd.clr_avg = 1'b1;
                        state_next  = ST_FLUSH;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FLUSH:
            begin
                cmd.out_valid  = 1'b1;
                cmd.flush_mode = 1'b1;
                if (status.out_ready)
                begin
                    cmd.flush_step = 1'b1;
                    if (status.flush_one)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A new request is never taken while a result is still offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.in_ready && cmd.out_valid))
        else $error("request accepted while a result is pending");

    // The history read sequence always ends with the drain cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ && status.last_issue) |=> (state_reg == ST_DRAIN))
        else $error("read sequence did not drain");

    // Zero-fill results are only entered once the frame has ended.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(cmd.flush_mode) |-> status.has_flush)
        else $error("flush started without a frame end");

endmodule
`default_nettype wire

>>> hdl/cmaf_dp.sv
// Datapath of the box filter: history RAM, accumulator, reciprocal divider and output register.
`default_nettype none
module cmaf_dp (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cmaf_pkg::cmaf_cmd_t    cmd,
    output cmaf_pkg::cmaf_status_t      status,
    cmaf_cfg_if.sink                    cfg,
    cmaf_sample_if.sink                 samples,
    cmaf_result_if.source               results
);
    import cmaf_pkg::*;

    logic [WINDOW_BITS-1:0]        window_reg, window_next;
    logic [ADDR_BITS-1:0]          wp_reg, wp_next;
    logic [ADDR_BITS-1:0]          base_reg, base_next;
    logic [COUNT_BITS-1:0]         count_reg, count_next;
    logic [COUNT_BITS-1:0]         k_reg, k_next;
    logic [SIDE_BITS-1:0]          side_reg, side_next;
    logic [WINDOW_BITS-1:0]        w_reg, w_next;
    logic                          end_reg, end_next;
    logic [SIDE_BITS-1:0]          fcnt_reg, fcnt_next;
    logic [ADDR_BITS-1:0]          idx_reg, idx_next;
    logic                          pend_reg, pend_next;
    logic signed [SUM_BITS-1:0]    acc_reg, acc_next;
    logic                          neg_reg, neg_next;
    logic [MAG_BITS-1:0]           mag_reg, mag_next;
    logic [PROD_BITS-1:0]          prod_reg, prod_next;
    logic signed [SAMPLE_BITS-1:0] avg_reg, avg_next;

    logic                          accept;
    logic [WINDOW_BITS-1:0]        eff_w;
    logic [SIDE_BITS-1:0]          side;
    logic [COUNT_BITS:0]           kp1;
    logic [ADDR_BITS-1:0]          side2;
    logic [ADDR_BITS-1:0]          raddr;
    logic [SAMPLE_BITS-1:0]        rdata;
    logic [MAG_BITS-1:0]           q0;
    logic [MAG_BITS+WINDOW_BITS-1:0] qw;
    logic [MAG_BITS-1:0]           rem;
    logic [MAG_BITS-1:0]           q;

    assign accept = samples.valid && cmd.in_ready;
    assign eff_w  = (window_reg == '0) ? WINDOW_BITS'(1) : window_reg;
    assign side   = SIDE_BITS'((eff_w - WINDOW_BITS'(1)) >> 1);
    assign kp1    = {1'b0, count_reg} + (COUNT_BITS+1)'(1);
    assign side2  = {side_reg, 1'b0};

    // The sample read sits idx_reg places behind the newest, modulo the ring size.
    assign raddr = (base_reg >= idx_reg) ? (base_reg - idx_reg)
                 : (base_reg + ADDR_BITS'(MAX_WINDOW) - idx_reg);

    cmaf_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_history (
        .clk   (clk),
        .we    (accept),
        .waddr (wp_reg),
        .wdata (samples.sample),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Reciprocal quotient is at most one low; one compare fixes it.
    assign q0  = prod_reg[PROD_BITS-1:RECIP_BITS];
    assign qw  = q0 * w_reg;
    assign rem = mag_reg - qw[MAG_BITS-1:0];
    assign q   = (rem >= MAG_BITS'(w_reg)) ? (q0 + MAG_BITS'(1)) : q0;

    always_comb
    begin
        window_next = window_reg;
        wp_next     = wp_reg;
        base_next   = base_reg;
        count_next  = count_reg;
        k_next      = k_reg;
        side_next   = side_reg;
        w_next      = w_reg;
        end_next    = end_reg;
        fcnt_next   = fcnt_reg;
        idx_next    = idx_reg;
        pend_next   = cmd.rd_issue;
        acc_next    = acc_reg;
        neg_next    = neg_reg;
        mag_next    = mag_reg;
        prod_next   = prod_reg;
        avg_next    = avg_reg;

        if (cfg.valid)
        begin
            window_next = cfg.data;
        end

        if (accept)
        begin
            wp_next   = (wp_reg == ADDR_BITS'(MAX_WINDOW - 1)) ? '0 : (wp_reg + ADDR_BITS'(1));
            base_next = wp_reg;
            k_next    = count_reg;
            side_next = side;
            w_next    = eff_w;
            end_next  = samples.frame_end;
            idx_next  = '0;
            acc_next  = '0;
            fcnt_next = (kp1 < (COUNT_BITS+1)'(side)) ? kp1[SIDE_BITS-1:0] : side;
            if (samples.frame_end)
            begin
                count_next = '0;
            end
            else if (count_reg != COUNT_BITS'(COUNT_MAX))
            begin
                count_next = kp1[COUNT_BITS-1:0];
            end
        end

        if (cmd.rd_issue)
        begin
            idx_next = idx_reg + ADDR_BITS'(1);
        end

        if (pend_reg)
        begin
            acc_next = acc_reg + {{(SUM_BITS-SAMPLE_BITS){rdata[SAMPLE_BITS-1]}}, rdata};
        end

        if (cmd.abs_en)
        begin
            neg_next = acc_reg[SUM_BITS-1];
            mag_next = acc_reg[SUM_BITS-1] ? MAG_BITS'(-acc_reg) : MAG_BITS'(acc_reg);
        end

        if (cmd.mul_en)
        begin
            prod_next = mag_reg * RECIP_TABLE[w_reg];
        end

        if (cmd.fix_en)
        begin
            avg_next = neg_reg ? -q[SAMPLE_BITS-1:0] : q[SAMPLE_BITS-1:0];
        end
        else if (cmd.clr_avg)
        begin
            avg_next = '0;
        end

        if (cmd.flush_step)
        begin
            fcnt_next = fcnt_reg - SIDE_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_BITS'(WINDOW_RESET);
            wp_reg     <= '0;
            count_reg  <= '0;
            k_reg      <= '0;
            side_reg   <= '0;
            end_reg    <= 1'b0;
            fcnt_reg   <= '0;
            idx_reg    <= '0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            window_reg <= window_next;
            wp_reg     <= wp_next;
            count_reg  <= count_next;
            k_reg      <= k_next;
            side_reg   <= side_next;
            end_reg    <= end_next;
            fcnt_reg   <= fcnt_next;
            idx_reg    <= idx_next;
            pend_reg   <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        w_reg    <= w_next;
        acc_reg  <= acc_next;
        neg_reg  <= neg_next;
        mag_reg  <= mag_next;
        prod_reg <= prod_next;
        avg_reg  <= avg_next;
    end

    assign cfg.ready       = 1'b1;
    assign samples.ready   = cmd.in_ready;
    assign results.valid   = cmd.out_valid;
    assign results.average = avg_reg;
    assign results.out_last = cmd.flush_mode ? (fcnt_reg == SIDE_BITS'(1))
                                             : (end_reg && (side_reg == '0));

    assign status.in_valid   = samples.valid;
    assign status.out_ready  = results.ready;
    assign status.full_sum   = k_reg >= COUNT_BITS'(side2);
    assign status.has_out    = k_reg >= COUNT_BITS'(side_reg);
    assign status.has_flush  = end_reg && (fcnt_reg != '0);
    assign status.last_issue = idx_reg == side2;
    assign status.flush_one  = fcnt_reg == SIDE_BITS'(1);

    // The zero-fill counter never underflows while zero results go out.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush_mode |-> (fcnt_reg != '0))
        else $error("flush counter ran out during flush");

    // History reads never reach beyond the current window.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_issue |-> (idx_reg <= side2))
        else $error("history read beyond the window");

    // The write pointer stays inside the ring.
    assert property (@(posedge clk) disable iff (!rst_n)
        wp_reg < ADDR_BITS'(MAX_WINDOW))
        else $error("write pointer outside the ring");

endmodule
`default_nettype wire

>>> hdl/centered_moving_average_filter_top.sv
// Top level of the centered moving-average box filter.
//
// Samples enter on the samples channel (valid/ready, a signed sample and a
// frame_end flag) and results leave on the results channel (average and
// out_last). The cfg channel writes the window length; it is always ready
// and should only be used while the filter holds no pending request.
// Each accepted request yields zero or more results: the centered window
// average delayed by half the window, zero until the window is full, and on
// the frame's last sample the pending outputs flushed as zeros, with out_last
// on the final one. The filter works on one request at a time. A request whose
// window is complete goes from the decide state through the history reads, which
// go one sample a cycle through the single read port of the history RAM, a
// drain state, the absolute value, the reciprocal multiply and its correction
// to the output register. Other requests go from the decide state straight to
// their result or back to ready; flushed zeros follow back to back while ready.
// When the receiver stalls, the result is held in the output register and no
// new sample is taken until all results of the current request are delivered.
// Reset sets the window to 3 and clears the frame count and write pointer;
// history contents are undefined but only samples of the current frame are read.
`default_nettype none
module centered_moving_average_filter_top (
    input  wire logic     clk,
    input  wire logic     rst_n,
    cmaf_cfg_if.sink      cfg,
    cmaf_sample_if.sink   samples,
    cmaf_result_if.source results
);
    import cmaf_pkg::*;

    cmaf_cmd_t    cmd;
    cmaf_status_t status;

    // The controller sequences one request at a time through the datapath.
    cmaf_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    // The datapath holds the history, the sum, the divider and the output.
    cmaf_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .status  (status),
        .cfg     (cfg),
        .samples (samples),
        .results (results)
    );

endmodule
`default_nettype wire

>>> verif/moving_average_checker.sv
// Checker that predicts the box filter's averages from observed requests and compares results.
module moving_average_checker (
    input  logic   clk,
    input  logic   rst_n,
    cmaf_cfg_if    cfg,
    cmaf_sample_if samples,
    cmaf_result_if results,
    output int     fail_count,
    output int     pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import cmaf_pkg::*;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] average;
        logic                          out_last;
    } avg_result_t;

    // Predicted filter state, kept at the block's own widths.
    logic [WINDOW_BITS-1:0]        window_reg;
    logic signed [SAMPLE_BITS-1:0] taps [MAX_WINDOW];
    logic [COUNT_BITS-1:0]         seen_in_frame;
    logic [ADDR_BITS-1:0]          slot;

    avg_result_t avg_expected [$];

    // Push the results one accepted sample causes and advance the frame state.
    task automatic filter_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic fe);
        int          w;
        int          side;
        int          k;
        int          total;
        int          flush;
        int          i;
        int          pos;
        avg_result_t item;
        w = int'(window_reg);
        if (w == 0)
            w = 1;
        if (w > MAX_WINDOW)
            w = MAX_WINDOW;
        side = (w - 1) / 2;
        k = int'(seen_in_frame);
        taps[slot] = s;
        if (k >= side) begin
            item.average = '0;
            if (k >= 2 * side) begin
                total = 0;
                for (i = 0; i <= 2 * side; i++) begin
                    pos = (int'(slot) + MAX_WINDOW - i) % MAX_WINDOW;
                    total += int'(taps[pos]);
                end
                item.average = SAMPLE_BITS'(total / w);
            end
            item.out_last = fe && (side == 0);
            avg_expected.push_back(item);
        end
        slot = (int'(slot) == MAX_WINDOW - 1) ? '0 : slot + 1'b1;
        seen_in_frame = (k >= COUNT_MAX) ? COUNT_BITS'(COUNT_MAX) : COUNT_BITS'(k + 1);
        if (fe) begin
            // The outputs still owed for the tail of the frame come out as zeros.
            flush = (int'(seen_in_frame) < side) ? int'(seen_in_frame) : side;
            for (i = 0; i < flush; i++) begin
                item.average = '0;
                item.out_last = (i + 1 == flush);
                avg_expected.push_back(item);
            end
            seen_in_frame = '0;
        end
    endtask

    task automatic check_result();
        avg_result_t want;
        if (avg_expected.size() == 0) begin
            fail_count++;
            $display("%0t: expected no result, actual average %0d out_last %0b", $time,
                     $signed(results.average), results.out_last);
        end else begin
            want = avg_expected.pop_front();
            if (results.average !== want.average) begin
                fail_count++;
                $display("%0t: average expected %0d, actual %0d", $time,
                         $signed(want.average), $signed(results.average));
            end
            if (results.out_last !== want.out_last) begin
                fail_count++;
                $display("%0t: out_last expected %0b, actual %0b", $time,
                         want.out_last, results.out_last);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            window_reg = WINDOW_BITS'(WINDOW_RESET);
            seen_in_frame = '0;
            slot = '0;
            for (int i = 0; i < MAX_WINDOW; i++)
                taps[i] = '0;
            avg_expected.delete();
            fail_count = 0;
            pending = 0;
        end else begin
            if (results.valid && results.ready)
                check_result();
            // A sample taken at the same edge as a register write still sees
            // the old window, as the block does.
            if (samples.valid && samples.ready)
                filter_sample(samples.sample, samples.frame_end);
            if (cfg.valid && cfg.ready)
                window_reg = cfg.data;
            pending = avg_expected.size();
        end
    end

endmodule

>>> verif/testbench.sv
// Top of the box filter testbench: clock, reset, stimulus, result back-pressure and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import cmaf_pkg::*;

    // The idle wait is comfortably longer than a window-complete request takes,
    // so that a request with no result has surely finished.
    localparam int DRAIN_CYCLES  = 40;
    // Longest legal stretch without any handshake, below the limit, is a long
    // sender gap, the filter latency, a long receiver stall and the drain wait.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 210;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    // Set for whole phases in which neither side inserts gaps.
    bit   quiet_phase;

    cmaf_cfg_if    cfg_ch();
    cmaf_sample_if sample_ch();
    cmaf_result_if result_ch();

    centered_moving_average_filter_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_ch),
        .samples (sample_ch),
        .results (result_ch)
    );

    moving_average_checker avg_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_ch),
        .samples    (sample_ch),
        .results    (result_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int roll;
        if (quiet_phase)
            return 0;
        roll = $urandom_range(0, 9);
        if (roll < 6)
            return 0;
        if (roll < 9)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Sample values lean toward the extremes and toward small magnitudes,
    // where sign handling and truncation toward zero are most exposed.
    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return SAMPLE_BITS'($urandom_range(0, 20) - 10);
            default: return SAMPLE_BITS'($urandom_range(0, 65535));
        endcase
    endfunction

    // Offers one request and returns at the rising edge that accepted it.
    // With no gap, valid stays high and only the payload changes.
    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic fe);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid     <= 1'b1;
        sample_ch.sample    <= s;
        sample_ch.frame_end <= fe;
        // Ready is sampled half a period before the edge, where it is stable.
        do @(negedge clk); while (!sample_ch.ready);
        @(posedge clk);
    endtask

    // Stops offering requests, waits for every predicted result to arrive and
    // then for the filter to finish any request that produces no result.
    task automatic settle();
        sample_ch.valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Writes the window register; only called while the filter is idle.
    task automatic write_window(input logic [WINDOW_BITS-1:0] w);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= w;
        do @(negedge clk); while (!cfg_ch.ready);
        @(posedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // The receiver alternates between accepting for a few cycles and stalling,
    // mostly briefly and sometimes for a long stretch.
    initial begin : result_ready_gen
        int hold;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (!quiet_phase && $urandom_range(0, 3) == 0) begin
                result_ch.ready <= 1'b0;
                hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(1, 3);
            end else begin
                result_ch.ready <= 1'b1;
                hold = $urandom_range(1, 6);
            end
            repeat (hold - 1) @(posedge clk);
        end
    end

    // Ends the run if no request, result or register write is accepted for
    // too long, which means the filter has hung.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((sample_ch.valid && sample_ch.ready) ||
                (result_ch.valid && result_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial begin : stimulus
        int                     sent;
        int                     phase;
        int                     phase_len;
        int                     frame_left;
        int                     w;
        int                     side;
        int                     roll;
        logic [WINDOW_BITS-1:0] window_val;

        quiet_phase = 1'b0;
        sample_ch.valid     <= 1'b0;
        sample_ch.sample    <= '0;
        sample_ch.frame_end <= 1'b0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.data         <= '0;
        rst_n               <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset window of three: a full-scale positive run falling to full-scale
        // negative, so the sums reach both extremes and the sign change between.
        send_sample(16'sh7fff, 1'b0);
        send_sample(16'sh7fff, 1'b0);
        send_sample(16'sh7fff, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh8000, 1'b1);
        // Frames shorter than the window: a single sample and a pair, all zeros.
        send_sample(16'sd5, 1'b1);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd1, 1'b1);
        settle();

        // A window of zero acts as a window of one: each output is its sample.
        write_window(4'd0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sh7fff, 1'b1);
        settle();

        // An even window sums one sample fewer than it divides by.
        write_window(4'd4);
        send_sample(16'sd100, 1'b0);
        send_sample(-16'sd7, 1'b0);
        send_sample(16'sd3, 1'b0);
        send_sample(16'sd9, 1'b1);
        settle();

        // The widest window with a short frame: only flushed zeros come out.
        write_window(4'd15);
        send_sample(16'sh7fff, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sd12345, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd0, 1'b1);
        settle();

        // Random phases. Each phase sets a window and then streams frames.
        // A frame may run past the end of its phase, so the window also
        // changes in the middle of frames. Most frames are long enough to
        // fill the window; some are long enough to saturate the frame count,
        // and a few are only one to three samples long.
        sent = 0;
        phase = 0;
        frame_left = 0;
        while (sent < RANDOM_ITEMS) begin
            case (phase)
                0:       window_val = 4'd15;
                1:       window_val = 4'd1;
                2:       window_val = 4'd2;
                default: window_val = WINDOW_BITS'($urandom_range(0, 15));
            endcase
            write_window(window_val);
            quiet_phase = ($urandom_range(0, 4) == 0);
            w = (window_val == 0) ? 1 : int'(window_val);
            side = (w - 1) / 2;
            phase_len = $urandom_range(15, 40);
            repeat (phase_len) begin
                if (frame_left == 0) begin
                    roll = $urandom_range(0, 19);
                    if (roll < 2)
                        frame_left = $urandom_range(1, 3);
                    else if (roll < 5)
                        frame_left = $urandom_range(25, 40);
                    else
                        frame_left = $urandom_range(2 * side + 1, 2 * side + 10);
                end
                send_sample(pick_sample(), frame_left == 1);
                frame_left--;
                sent++;
            end
            settle();
            phase++;
        end
        quiet_phase = 1'b0;

        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> files.f
hdl/cmaf_pkg.sv
hdl/cmaf_if.sv
hdl/cmaf_ram.sv
hdl/cmaf_ctrl.sv
hdl/cmaf_dp.sv
hdl/centered_moving_average_filter_top.sv
verif/moving_average_checker.sv
verif/testbench.sv
